FILE: hw/rtl/base64_custom_alphabet_encoder_defines.svh
// assertion macros for the base64 custom alphabet encoder
`ifndef BASE64_CUSTOM_ALPHABET_ENCODER_DEFINES_SVH
`define BASE64_CUSTOM_ALPHABET_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define B64E_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define B64E_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/b64e_pkg.sv
// package: types, constants and alphabet lookup for the base64 encoder
package b64e_pkg;

  localparam int unsigned B64E_QUEUE_DEPTH = 2;
  localparam logic [7:0]  CHAR_MASK        = 8'h42;
  localparam logic [7:0]  PAD_CHAR         = 8'h3D;

  // how many bytes of a group carry message data
  typedef enum logic [1:0] {
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_FULL = 2'd3
  } grp_kind_t;

  // one 24-bit group handed from the front to the back
  typedef struct packed {
    logic [23:0] bits;
    grp_kind_t   kind;
    logic        last;
  } grp_t;

  localparam logic [7:0] ALPHABET [64] = '{
    8'h01, 8'h16, 8'h35, 8'h05, 8'h2a, 8'h21, 8'h08, 8'h28,
    8'h69, 8'h2c, 8'h09, 8'h11, 8'h33, 8'h03, 8'h10, 8'h31,
    8'h13, 8'h70, 8'h75, 8'h2d, 8'h2f, 8'h1a, 8'h72, 8'h0b,
    8'h2e, 8'h27, 8'h3b, 8'h7b, 8'h73, 8'h37, 8'h24, 8'h06,
    8'h20, 8'h12, 8'h3a, 8'h14, 8'h1b, 8'h76, 8'h23, 8'h30,
    8'h77, 8'h17, 8'h25, 8'h0f, 8'h0c, 8'h36, 8'h6d, 8'h0e,
    8'h71, 8'h00, 8'h34, 8'h38, 8'h29, 8'h04, 8'h2b, 8'h0a,
    8'h18, 8'h15, 8'h74, 8'h26, 8'h0d, 8'h32, 8'h7a, 8'h07
  };

  // 6-bit index to output character
  function automatic logic [7:0] enc6(input logic [5:0] idx);
    enc6 = ALPHABET[idx] ^ CHAR_MASK;
  endfunction

endpackage

FILE: hw/rtl/b64e_if.sv
// request channel interfaces for bytes in and characters out
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_char;
  logic       last_char;

  modport source (output valid, output code_char, output last_char, input ready);
  modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

FILE: hw/rtl/b64e_front.sv
// front: gathers bytes into groups of three and classifies group endings
module b64e_front (
  input  logic           clk,
  input  logic           rst_n,
  b64e_in_if.sink        in_req,
  input  logic           q_full,
  output logic           push,
  output b64e_pkg::grp_t grp
);
  import b64e_pkg::*;

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;

  // a request is taken whenever the queue has room
  assign in_req.ready = !q_full;
  assign accept       = in_req.valid && in_req.ready;

  // classify the byte and build the group record
  always_comb begin
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    grp.bits  = {pend_r, in_req.data_byte};
    grp.kind  = KIND_FULL;
    grp.last  = in_req.end_of_message;
    if (accept) begin
      if (cnt_r == 2'd2) begin
        push    = 1'b1;
        cnt_nxt = 2'd0;
      end else if (in_req.end_of_message) begin
        push    = 1'b1;
        cnt_nxt = 2'd0;
        if (cnt_r == 2'd0) begin
          grp.bits = {in_req.data_byte, 16'h0000};
          grp.kind = KIND_ONE;
        end else begin
          grp.bits = {pend_r[15:8], in_req.data_byte, 8'h00};
          grp.kind = KIND_TWO;
        end
      end else begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd0) begin
          pend_nxt = {in_req.data_byte, 8'h00};
        end else begin
          pend_nxt = {pend_r[15:8], in_req.data_byte};
        end
      end
    end
  end

  // pending state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      pend_r <= 16'h0000;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: hw/rtl/b64e_fifo.sv
// short group queue between front and back
module b64e_fifo #(
  parameter int unsigned DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::grp_t wr_grp,
  input  logic           pop,
  output b64e_pkg::grp_t head,
  output logic           full,
  output logic           empty
);
  import b64e_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  grp_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head  = slot_r[rd_ptr_r];
  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_grp;
    end
  end

endmodule

FILE: hw/rtl/b64e_back.sv
// back: splits each group into four characters, one per cycle while the output is not stalled
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b64e_pkg::grp_t head,
  input  logic           q_empty,
  output logic           pop,
  b64e_out_if.source     out_req
);
  import b64e_pkg::*;

  grp_t       cur_r, cur_nxt;
  logic       active_r, active_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       load, emit, done;
  logic [5:0] slice;
  logic       is_pad;

  assign load = !out_valid_r || out_req.ready;
  assign emit = active_r && load;
  assign done = emit && (idx_r == 2'd3);
  assign pop  = !q_empty && (!active_r || done);

  // pick the 6-bit slice for the current character, most significant first
  always_comb begin
    case (idx_r)
      2'd0:    slice = cur_r.bits[23:18];
      2'd1:    slice = cur_r.bits[17:12];
      2'd2:    slice = cur_r.bits[11:6];
      2'd3:    slice = cur_r.bits[5:0];
      default: slice = cur_r.bits[5:0];
    endcase
  end

  // padding positions depend on how many bytes the group holds
  always_comb begin
    case (cur_r.kind)
      KIND_ONE:  is_pad = idx_r[1];
      KIND_TWO:  is_pad = (idx_r == 2'd3);
      KIND_FULL: is_pad = 1'b0;
      default:   is_pad = 1'b0;
    endcase
  end

  // group sequencing and output register
  always_comb begin
    cur_nxt       = cur_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    if (pop) begin
      cur_nxt    = head;
      active_nxt = 1'b1;
      idx_nxt    = 2'd0;
    end else if (done) begin
      active_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (load) begin
      out_valid_nxt = emit;
      char_nxt      = is_pad ? PAD_CHAR : enc6(slice);
      last_nxt      = (idx_r == 2'd3) && cur_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_req.valid     = out_valid_r;
  assign out_req.code_char = char_r;
  assign out_req.last_char = last_r;

endmodule

FILE: hw/rtl/base64_custom_alphabet_encoder.sv
// top level of the streaming base64 encoder with custom alphabet
//
//   channel   direction  payload                        request when
//   in_req    sink       data_byte[7:0], end_of_message  valid && ready
//   out_req   source     code_char[7:0], last_char       valid && ready
//
// a byte is taken each cycle while the group queue has room; the front
// holds up to two bytes and hands on each finished group in that cycle
// every group leaves as four characters, one per cycle from the output
// register while the output is free-running; the back sets the rate;
// bytes keep coming while up to QUEUE_DEPTH groups wait behind a stalled
// output; synchronous active-low reset empties all
`include "base64_custom_alphabet_encoder_defines.svh"

module base64_custom_alphabet_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if.sink    in_req,
  b64e_out_if.source out_req
);
  import b64e_pkg::*;

  grp_t grp;
  grp_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic eom_take;

  // byte gathering and group classification
  b64e_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .q_full (q_full),
    .push   (push),
    .grp    (grp)
  );

  // group queue
  b64e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_grp (grp),
    .pop    (pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // character generation
  b64e_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .out_req (out_req)
  );

  // end of message request taken this cycle
  assign eom_take = in_req.valid && in_req.ready && in_req.end_of_message;

  // checks
  `B64E_ASSERT_NOW(a_push_room, push, !q_full, "group pushed into a full queue")
  `B64E_ASSERT_NOW(a_eom_push, eom_take, push, "end of message request produced no group")
  `B64E_ASSERT_NEXT(a_push_lands, push && !pop, !q_empty, "pushed group not visible in queue")
  `B64E_ASSERT_NOW(a_pop_nonempty, pop, !q_empty, "group popped from an empty queue")

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the streaming base64 encoder with custom alphabet
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS = 445;
  localparam int          MAX_WAIT     = 11;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam logic [7:0]  XOR_KEY      = 8'h42;
  localparam logic [7:0]  PAD_CODE     = 8'h3D;

  // substitution table before the xor key is applied
  localparam logic [7:0] SYMBOLS [64] = '{
    8'h01, 8'h16, 8'h35, 8'h05, 8'h2a, 8'h21, 8'h08, 8'h28,
    8'h69, 8'h2c, 8'h09, 8'h11, 8'h33, 8'h03, 8'h10, 8'h31,
    8'h13, 8'h70, 8'h75, 8'h2d, 8'h2f, 8'h1a, 8'h72, 8'h0b,
    8'h2e, 8'h27, 8'h3b, 8'h7b, 8'h73, 8'h37, 8'h24, 8'h06,
    8'h20, 8'h12, 8'h3a, 8'h14, 8'h1b, 8'h76, 8'h23, 8'h30,
    8'h77, 8'h17, 8'h25, 8'h0f, 8'h0c, 8'h36, 8'h6d, 8'h0e,
    8'h71, 8'h00, 8'h34, 8'h38, 8'h29, 8'h04, 8'h2b, 8'h0a,
    8'h18, 8'h15, 8'h74, 8'h26, 8'h0d, 8'h32, 8'h7a, 8'h07
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } code_char_t;

  // one directed request; chars holds four typed characters, first in 31:24
  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic        typed;
    logic [31:0] chars;
  } byte_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam byte_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 32'h4343_3D3D},  // lone zero byte
    '{8'hFF, 1'b1, 1'b1, 32'h4533_3D3D},  // lone all-ones byte
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 32'h4343_4343},  // full zero group closing the message
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b1, 32'h4545_4545},  // full all-ones group
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 32'h4343_433D},  // two zero bytes, one pad
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b0, 32'h0},
    '{8'h12, 1'b0, 1'b0, 32'h0},          // full group without end
    '{8'h34, 1'b0, 1'b0, 32'h0},
    '{8'h56, 1'b0, 1'b0, 32'h0},
    '{8'h78, 1'b1, 1'b0, 32'h0},          // then a single trailing byte
    '{8'hA5, 1'b0, 1'b0, 32'h0},
    '{8'h5A, 1'b1, 1'b0, 32'h0},
    '{8'hC3, 1'b0, 1'b0, 32'h0},
    '{8'h3C, 1'b0, 1'b0, 32'h0},
    '{8'h96, 1'b0, 1'b0, 32'h0},
    '{8'h69, 1'b0, 1'b0, 32'h0},
    '{8'h0F, 1'b1, 1'b0, 32'h0}
  };

  logic clk;
  logic rst_n;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_custom_alphabet_encoder DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_req (out_ch)
  );

  // encoder state mirror and the characters still owed by the block
  logic [15:0]  held_bytes;
  logic [1:0]   held_count;
  code_char_t   chars_due [$];

  int  fails;
  int  cycles;
  int  bytes_sent;
  int  messages_sent;
  int  chars_seen;
  int  drain_pauses;
  bit  quiet_tx;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] sym6(input logic [5:0] idx);
    return SYMBOLS[idx] ^ XOR_KEY;
  endfunction

  // advance the mirror by one byte; returns how many characters it releases
  function automatic int encode_byte(input logic [7:0] b, input logic eom,
                                     output logic [31:0] chars);
    logic [23:0] grp;
    chars = '0;
    if (held_count == 2'd2) begin
      grp = {held_bytes, b};
      chars = {sym6(grp[23:18]), sym6(grp[17:12]), sym6(grp[11:6]), sym6(grp[5:0])};
      held_bytes = '0;
      held_count = '0;
      return 4;
    end
    if (!eom) begin
      if (held_count == 2'd0) held_bytes = {b, 8'h00};
      else held_bytes[7:0] = b;
      held_count = held_count + 2'd1;
      return 0;
    end
    if (held_count == 2'd0) begin
      grp = {b, 16'h0000};
      chars = {sym6(grp[23:18]), sym6(grp[17:12]), PAD_CODE, PAD_CODE};
    end else begin
      grp = {held_bytes[15:8], b, 8'h00};
      chars = {sym6(grp[23:18]), sym6(grp[17:12]), sym6(grp[11:6]), PAD_CODE};
    end
    held_bytes = '0;
    held_count = '0;
    return 4;
  endfunction

  task automatic note_mismatch(input string msg);
    fails++;
    if (fails <= 10) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // offer one byte request and book the characters it should release
  task automatic send_byte(input logic [7:0] b, input logic eom,
                           input logic typed, input logic [31:0] typed_chars);
    int          gap;
    int          n;
    logic [31:0] chars;
    code_char_t  c;
    gap = quiet_tx ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    n = encode_byte(b, eom, chars);
    if (typed) chars = typed_chars;
    for (int k = 0; k < n; k++) begin
      c.ch   = chars[31 - 8 * k -: 8];
      c.last = eom && (k == n - 1);
      chars_due.push_back(c);
    end
    if (eom) messages_sent++;
  endtask

  // hold off the sender until every booked character has come out
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_due.size() != 0);
    drain_pauses++;
  endtask

  // result checker
  always @(posedge clk) begin
    code_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      chars_seen++;
      if (chars_due.size() == 0) begin
        note_mismatch($sformatf("unexpected char %h last %b",
                                out_ch.code_char, out_ch.last_char));
      end else begin
        want = chars_due.pop_front();
        if (out_ch.code_char !== want.ch)
          note_mismatch($sformatf("code_char expected %h got %h",
                                  want.ch, out_ch.code_char));
        if (out_ch.last_char !== want.last)
          note_mismatch($sformatf("last_char expected %b got %b",
                                  want.last, out_ch.last_char));
      end
    end
  end

  // result side back-pressure, with calm stretches
  initial begin
    int gap;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  // stimulus and end of run
  initial begin
    int         len;
    int         pick;
    int         rand_sent;
    logic [7:0] b;
    fails         = 0;
    cycles        = 0;
    bytes_sent    = 0;
    messages_sent = 0;
    chars_seen    = 0;
    drain_pauses  = 0;
    rand_sent     = 0;
    quiet_tx      = 1'b0;
    held_bytes    = '0;
    held_count    = '0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.end_of_message = 1'b0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: extremes, every group length, ends after full groups
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (i % 8 == 0) quiet_tx = ~quiet_tx;
      send_byte(DIRECTED[i].data, DIRECTED[i].eom, DIRECTED[i].typed, DIRECTED[i].chars);
    end
    hold_until_drained();

    // random messages, mostly short, some long, extremes weighted in
    while (rand_sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      quiet_tx = ($urandom_range(0, 4) == 0);
      for (int j = 0; j < len; j++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) b = 8'h00;
        else if (pick == 1) b = 8'hFF;
        else b = $urandom_range(0, 255);
        send_byte(b, j == len - 1, 1'b0, 32'h0);
      end
      rand_sent += len;
      if (messages_sent % 9 == 0) hold_until_drained();
    end
    in_ch.valid <= 1'b0;

    // let the block empty, then watch a little longer for strays
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d byte requests in %0d messages, %0d characters checked",
             bytes_sent, messages_sent, chars_seen);
    $display("%0d directed rows, %0d full drain pauses, %0d mismatches",
             DIRECTED_ROWS, drain_pauses, fails);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
